// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define FFP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ffp_pkg.sv -----
package ffp_pkg;

	localparam int LENGTH_BITS = 32;

	typedef logic [LENGTH_BITS-1:0] len_t;

	localparam len_t COUNT_MAX = '1;

	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_SP   = 8'h20;

	typedef enum logic [3:0] {
		PH_FIRST        = 4'd0,
		PH_NAME_WAIT    = 4'd1,
		PH_NAME         = 4'd2,
		PH_COMMENT_LEAD = 4'd3,
		PH_COMMENT      = 4'd4,
		PH_SEQ_START    = 4'd5,
		PH_SEQ_NL       = 4'd6,
		PH_SEQ_SKIP     = 4'd7,
		PH_SEQ_TOKEN    = 4'd8,
		PH_QUAL_LINE    = 4'd9,
		PH_QUAL_SKIP    = 4'd10,
		PH_QUAL_TOKEN   = 4'd11,
		PH_SKIP_BOR     = 4'd12
	} phase_t;

	typedef enum logic [2:0] {
		KIND_NAME    = 3'd0,
		KIND_COMMENT = 3'd1,
		KIND_SEQ     = 3'd2,
		KIND_QUAL    = 3'd3,
		KIND_REC_END = 3'd4
	} kind_t;

	// space, tab, newline, vertical tab, form feed, return
	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SP) || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic len_t sat_inc(input len_t v);
		return (v == COUNT_MAX) ? v : v + len_t'(1);
	endfunction

endpackage

// ----- rtl/fastq_fasta_record_parser.sv -----
// Channel | Handshake             | Payload
// input   | in_valid / in_stall   | data_byte[7:0], end_of_input
// output  | out_valid / out_stall | field_kind[2:0], char_value[7:0], record_last, fastq_format
//
// One byte per cycle sustained while the output is not stalled. A transferred byte is
// parsed from the input register; its result, if any, then goes to the result register.
// Phase and the saturating length counters update as the byte is parsed; the increment
// and the quality/sequence length compare set the critical path.
// arst_n clears phase, mode, counters and both valid flags asynchronously.
// An output stall holds the result register and, with a byte waiting, raises in_stall.
module fastq_fasta_record_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] field_kind,
	output logic [7:0] char_value,
	output logic       record_last,
	output logic       fastq_format
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	// parser state
	ffp_pkg::phase_t phase_q, phase_n;
	logic            mode_q, mode_n;
	logic            open_q, open_n;
	ffp_pkg::len_t   seq_q, seq_n;
	ffp_pkg::len_t   qual_q, qual_n;

	// result of the byte in s1
	logic            emit;
	ffp_pkg::kind_t  kind;
	logic [7:0]      ch;
	logic            emit_mode;

	// result register
	logic            out_valid_q;
	ffp_pkg::kind_t  kind_q;
	logic [7:0]      ch_q;
	logic            mode_out_q;

	logic out_free;
	logic proc;
	logic [7:0] eos;
	logic [7:0] bor;

	assign out_free = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	assign eos = mode_q ? ffp_pkg::CH_PLUS : ffp_pkg::CH_GT;
	assign bor = mode_q ? ffp_pkg::CH_AT : ffp_pkg::CH_GT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			eoi_s1  <= end_of_input;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		mode_n    = mode_q;
		open_n    = open_q;
		seq_n     = seq_q;
		qual_n    = qual_q;
		emit      = 1'b0;
		kind      = ffp_pkg::KIND_NAME;
		ch        = byte_s1;
		emit_mode = mode_q;

		if (eoi_s1) begin
			// close any open record, then wait for a new stream
			emit    = open_q;
			kind    = ffp_pkg::KIND_REC_END;
			ch      = 8'h00;
			phase_n = ffp_pkg::PH_FIRST;
			mode_n  = 1'b0;
			open_n  = 1'b0;
			seq_n   = '0;
			qual_n  = '0;
		end else begin
			case (phase_q)
				ffp_pkg::PH_NAME_WAIT: begin
					if (!ffp_pkg::is_ws(byte_s1)) begin
						open_n  = 1'b1;
						phase_n = ffp_pkg::PH_NAME;
						emit    = 1'b1;
						kind    = ffp_pkg::KIND_NAME;
					end
				end
				ffp_pkg::PH_NAME: begin
					if (!ffp_pkg::is_ws(byte_s1)) begin
						emit = 1'b1;
						kind = ffp_pkg::KIND_NAME;
					end else if (byte_s1 == ffp_pkg::CH_SP) begin
						phase_n = ffp_pkg::PH_COMMENT_LEAD;
					end else if (byte_s1 == ffp_pkg::CH_NL) begin
						phase_n = ffp_pkg::PH_SEQ_START;
					end else begin
						// other whitespace opens the comment and is kept
						phase_n = ffp_pkg::PH_COMMENT;
						emit    = 1'b1;
						kind    = ffp_pkg::KIND_COMMENT;
					end
				end
				ffp_pkg::PH_COMMENT_LEAD: begin
					if (byte_s1 == ffp_pkg::CH_NL) begin
						phase_n = ffp_pkg::PH_SEQ_START;
					end else if (byte_s1 != ffp_pkg::CH_SP) begin
						phase_n = ffp_pkg::PH_COMMENT;
						emit    = 1'b1;
						kind    = ffp_pkg::KIND_COMMENT;
					end
				end
				ffp_pkg::PH_COMMENT: begin
					if (byte_s1 == ffp_pkg::CH_NL) begin
						phase_n = ffp_pkg::PH_SEQ_START;
					end else begin
						emit = 1'b1;
						kind = ffp_pkg::KIND_COMMENT;
					end
				end
				ffp_pkg::PH_SEQ_START, ffp_pkg::PH_SEQ_NL: begin
					// check point: end delimiter, else skip whitespace or start a token
					if (byte_s1 == eos) begin
						if (mode_q) begin
							phase_n = ffp_pkg::PH_QUAL_LINE;
						end else begin
							emit    = 1'b1;
							kind    = ffp_pkg::KIND_REC_END;
							ch      = 8'h00;
							open_n  = 1'b0;
							seq_n   = '0;
							qual_n  = '0;
							phase_n = ffp_pkg::PH_NAME_WAIT;
						end
					end else if (phase_q == ffp_pkg::PH_SEQ_NL &&
							byte_s1 == ffp_pkg::CH_NL) begin
						phase_n = ffp_pkg::PH_SEQ_NL;
					end else if (ffp_pkg::is_ws(byte_s1)) begin
						phase_n = ffp_pkg::PH_SEQ_SKIP;
					end else begin
						seq_n   = ffp_pkg::sat_inc(seq_q);
						phase_n = ffp_pkg::PH_SEQ_TOKEN;
						emit    = 1'b1;
						kind    = ffp_pkg::KIND_SEQ;
					end
				end
				ffp_pkg::PH_SEQ_SKIP: begin
					if (!ffp_pkg::is_ws(byte_s1)) begin
						seq_n   = ffp_pkg::sat_inc(seq_q);
						phase_n = ffp_pkg::PH_SEQ_TOKEN;
						emit    = 1'b1;
						kind    = ffp_pkg::KIND_SEQ;
					end
				end
				ffp_pkg::PH_SEQ_TOKEN: begin
					if (!ffp_pkg::is_ws(byte_s1)) begin
						seq_n = ffp_pkg::sat_inc(seq_q);
						emit  = 1'b1;
						kind  = ffp_pkg::KIND_SEQ;
					end else if (byte_s1 == ffp_pkg::CH_NL) begin
						phase_n = ffp_pkg::PH_SEQ_NL;
					end else begin
						phase_n = ffp_pkg::PH_SEQ_SKIP;
					end
				end
				ffp_pkg::PH_QUAL_LINE: begin
					// rest of the '+' line is dropped
					if (byte_s1 == ffp_pkg::CH_NL) begin
						phase_n = (qual_q < seq_q) ? ffp_pkg::PH_QUAL_SKIP
							: ffp_pkg::PH_SKIP_BOR;
					end
				end
				ffp_pkg::PH_QUAL_SKIP: begin
					if (!ffp_pkg::is_ws(byte_s1)) begin
						qual_n  = ffp_pkg::sat_inc(qual_q);
						phase_n = ffp_pkg::PH_QUAL_TOKEN;
						emit    = 1'b1;
						kind    = ffp_pkg::KIND_QUAL;
					end
				end
				ffp_pkg::PH_QUAL_TOKEN: begin
					if (!ffp_pkg::is_ws(byte_s1)) begin
						qual_n = ffp_pkg::sat_inc(qual_q);
						emit   = 1'b1;
						kind   = ffp_pkg::KIND_QUAL;
					end else begin
						phase_n = (qual_q < seq_q) ? ffp_pkg::PH_QUAL_SKIP
							: ffp_pkg::PH_SKIP_BOR;
					end
				end
				ffp_pkg::PH_SKIP_BOR: begin
					if (byte_s1 == bor) begin
						emit    = 1'b1;
						kind    = ffp_pkg::KIND_REC_END;
						ch      = 8'h00;
						open_n  = 1'b0;
						seq_n   = '0;
						qual_n  = '0;
						phase_n = ffp_pkg::PH_NAME_WAIT;
					end
				end
				default: begin
					// first byte of a stream picks the format and is consumed
					mode_n  = (byte_s1 == ffp_pkg::CH_AT);
					open_n  = 1'b0;
					seq_n   = '0;
					qual_n  = '0;
					phase_n = ffp_pkg::PH_NAME_WAIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ffp_pkg::PH_FIRST;
			mode_q  <= 1'b0;
			open_q  <= 1'b0;
			seq_q   <= '0;
			qual_q  <= '0;
		end else if (proc) begin
			phase_q <= phase_n;
			mode_q  <= mode_n;
			open_q  <= open_n;
			seq_q   <= seq_n;
			qual_q  <= qual_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= proc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			kind_q     <= kind;
			ch_q       <= ch;
			mode_out_q <= emit_mode;
		end
	end

	assign out_valid    = out_valid_q;
	assign field_kind   = kind_q;
	assign char_value   = ch_q;
	assign record_last  = (kind_q == ffp_pkg::KIND_REC_END);
	assign fastq_format = mode_out_q;

endmodule

// ----- rtl/ffp_checker.sv -----
`include "assert_macros.svh"

module ffp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] field_kind,
	input logic [7:0] char_value,
	input logic       record_last
);

	logic        marker;
	logic        marker_ok;
	logic        held;
	logic [10:0] out_word;

	assign marker    = out_valid && record_last;
	assign marker_ok = (field_kind == ffp_pkg::KIND_REC_END) && (char_value == 8'h00);
	assign held      = out_valid && out_stall;
	assign out_word  = {field_kind, char_value};

	`FFP_ASSERT_ALWAYS(a_reset_no_result, clk, !arst_n |=> !out_valid, "result during reset")

	`FFP_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> out_valid && out_stall, "stray stall")

	`FFP_ASSERT(a_marker_form, clk, arst_n, marker |-> marker_ok, "malformed record end")

	`FFP_ASSERT(a_out_hold, clk, arst_n, held |=> out_valid && $stable(out_word), "result moved")

endmodule

bind fastq_fasta_record_parser ffp_checker u_ffp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.field_kind  (field_kind),
	.char_value  (char_value),
	.record_last (record_last)
);
